### rtl/core/mfpc_pkg.sv
// Shared types, constants and helpers for the motor fader position controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mfpc_pkg;

	localparam int ADC_BITS        = 12;
	localparam int POS_W           = 8;
	localparam int INTERVAL_W      = 16;
	localparam int TIMER_BITS_DEF  = 16;
	localparam int PROD_W          = 2 * POS_W;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [POS_W-1:0] FAR_LIMIT  = 8'd80;
	localparam logic [POS_W-1:0] NEAR_LIMIT = 8'd15;
	localparam logic [POS_W-1:0] LIN_DIV    = 8'd65;
	localparam logic [POS_W-1:0] QUAD_DIV   = 8'd225;

	localparam logic [POS_W-1:0]      RST_POS_HIGH = 8'd250;
	localparam logic [POS_W-1:0]      RST_POS_LOW  = 8'd10;
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd2000;
	localparam logic [POS_W-1:0]      RST_DEADBAND = 8'd4;
	localparam logic [POS_W-1:0]      RST_MIN_SPD  = 8'd80;
	localparam logic [POS_W-1:0]      RST_MAX_SPD  = 8'd255;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_POS_HIGH = 3'd0,
		REG_POS_LOW  = 3'd1,
		REG_INTERVAL = 3'd2,
		REG_DEADBAND = 3'd3,
		REG_MIN_SPD  = 3'd4,
		REG_MAX_SPD  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic                op;
		logic [ADC_BITS-1:0] adc_sample;
	} mfpc_in_t;

	typedef struct packed {
		logic [POS_W-1:0] pwm_down;
		logic [POS_W-1:0] pwm_up;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] target;
		logic             at_target;
	} mfpc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} serial_stat_t;

	function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
			input logic [POS_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

### rtl/core/motor_fader_position_controller.sv
// Top level of the motor fader position controller: control sequencer, settings,
// tracking state and result register. Depends on mfpc_pkg, mfpc_mul, mfpc_div.
//
// Usage:
//   sample / sample_valid / sample_ready carry input items: op selects a converter
//   sample or a one millisecond tick. result / result_valid / result_ready carry
//   one result item per input item, in order. cfg_valid / cfg_ready / cfg_addr /
//   cfg_wdata write the six settings; cfg_ready is always high, writes are meant
//   for idle periods and unused addresses are dropped.
//   A tick goes from the idle state straight to the finish state; a sample inside
//   the deadband or at full speed passes the calculation state first, and a sample
//   that needs the eased speed also runs the bit-serial multiplier and then the
//   bit-serial divider. One item is in work at a time; the next can be taken in
//   the cycle after the result is written.
//   The result register frees the core: the next item is taken while a finished
//   result waits. If the receiver stalls, the following item finishes its work
//   and then holds until the result register drains.
//   Reset is asynchronous, active low: settings take their default values, the
//   target starts at the high position, the motor counts as stopped, and no
//   result is pending. No clearing pass is needed.
`default_nettype none

module motor_fader_position_controller
	import mfpc_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire mfpc_in_t              sample,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output mfpc_out_t                  result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CMP_W = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;

	// settings
	logic [POS_W-1:0]      pos_high_q;
	logic [POS_W-1:0]      pos_low_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [POS_W-1:0]      deadband_q;
	logic [POS_W-1:0]      min_spd_q;
	logic [POS_W-1:0]      max_spd_q;

	// tracking state
	logic                  target_high_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic                  settled_q;
	logic [POS_W-1:0]      last_pos_q;
	logic [POS_W-1:0]      pwm_down_q;
	logic [POS_W-1:0]      pwm_up_q;

	// item in work
	ctrl_state_t      state_q;
	ctrl_state_t      state_nxt;
	logic             op_q;
	logic [POS_W-1:0] pos_q;
	logic             in_db_q;
	logic             far_q;
	logic             quad_q;
	logic             down_q;

	mfpc_out_t result_q;
	logic      result_valid_q;

	// sequencer controls
	logic slot_free;
	logic mul_start;
	logic div_start;
	logic fin_fire;

	// distance and easing setup
	logic [POS_W-1:0]  tgt_cur;
	logic [POS_W-1:0]  gap;
	logic              in_db;
	logic              far;
	logic              quad;
	logic [POS_W-1:0]  ease_m;
	logic [POS_W-1:0]  span;
	logic [PROD_W-1:0] prod;
	logic [POS_W-1:0]  quot;
	serial_stat_t      mul_stat;
	serial_stat_t      div_stat;

	// next state of the tracker
	logic [POS_W-1:0]      speed;
	logic                  tick_inc;
	logic [TIMER_BITS-1:0] elapsed_inc;
	logic                  toggle;
	logic                  nxt_target_high;
	logic [TIMER_BITS-1:0] nxt_elapsed;
	logic                  nxt_settled;
	logic [POS_W-1:0]      nxt_last_pos;
	logic [POS_W-1:0]      nxt_pwm_down;
	logic [POS_W-1:0]      nxt_pwm_up;
	logic [POS_W-1:0]      nxt_target;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_high_q <= RST_POS_HIGH;
			pos_low_q  <= RST_POS_LOW;
			interval_q <= RST_INTERVAL;
			deadband_q <= RST_DEADBAND;
			min_spd_q  <= RST_MIN_SPD;
			max_spd_q  <= RST_MAX_SPD;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_addr))
				REG_POS_HIGH: begin
					pos_high_q <= cfg_wdata[POS_W-1:0];
				end
				REG_POS_LOW: begin
					pos_low_q <= cfg_wdata[POS_W-1:0];
				end
				REG_INTERVAL: begin
					interval_q <= cfg_wdata[INTERVAL_W-1:0];
				end
				REG_DEADBAND: begin
					deadband_q <= cfg_wdata[POS_W-1:0];
				end
				REG_MIN_SPD: begin
					min_spd_q <= cfg_wdata[POS_W-1:0];
				end
				REG_MAX_SPD: begin
					max_spd_q <= cfg_wdata[POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		tgt_cur = target_high_q ? pos_high_q : pos_low_q;
		gap     = abs_diff(pos_q, tgt_cur);
		in_db   = (gap <= deadband_q);
		far     = (gap > FAR_LIMIT);
		quad    = (gap <= NEAR_LIMIT);
		ease_m  = quad ? POS_W'({4'b0, gap[3:0]} * {4'b0, gap[3:0]}) : (gap - NEAR_LIMIT);
		span    = (max_spd_q > min_spd_q) ? (max_spd_q - min_spd_q) : '0;
	end

	assign slot_free = !result_valid_q || result_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_nxt = (sample.op == OP_TICK) ? ST_FIN : ST_CALC;
				end
			end
			ST_CALC: begin
				state_nxt = (in_db || far) ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		mul_start    = 1'b0;
		div_start    = 1'b0;
		fin_fire     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
			end
			ST_CALC: begin
				mul_start = !in_db && !far;
			end
			ST_MUL: begin
				div_start = mul_stat.done;
			end
			ST_DIV: begin
			end
			ST_FIN: begin
				fin_fire = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			op_q  <= sample.op;
			pos_q <= sample.adc_sample[ADC_BITS-1 -: POS_W];
		end
		if (state_q == ST_CALC) begin
			in_db_q <= in_db;
			far_q   <= far;
			quad_q  <= quad;
			down_q  <= (pos_q > tgt_cur);
		end
	end

	mfpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (span),
		.mplier (ease_m),
		.prod   (prod),
		.stat   (mul_stat)
	);

	mfpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.quad   (quad_q),
		.quot   (quot),
		.stat   (div_stat)
	);

	always_comb begin
		speed       = far_q ? max_spd_q : (quot + min_spd_q);
		tick_inc    = (CMP_W'(elapsed_q) < CMP_W'(interval_q)) && (elapsed_q != '1);
		elapsed_inc = tick_inc ? (elapsed_q + 1'b1) : elapsed_q;
		toggle      = settled_q && (CMP_W'(elapsed_inc) >= CMP_W'(interval_q));

		nxt_target_high = target_high_q;
		nxt_elapsed     = elapsed_q;
		nxt_settled     = settled_q;
		nxt_last_pos    = last_pos_q;
		nxt_pwm_down    = pwm_down_q;
		nxt_pwm_up      = pwm_up_q;

		if (op_q == OP_SAMPLE) begin
			nxt_last_pos = pos_q;
			nxt_settled  = in_db_q;
			nxt_pwm_down = (!in_db_q && down_q) ? speed : '0;
			nxt_pwm_up   = (!in_db_q && !down_q) ? speed : '0;
		end else begin
			nxt_elapsed = toggle ? '0 : elapsed_inc;
			if (toggle) begin
				nxt_target_high = !target_high_q;
				nxt_settled = (abs_diff(last_pos_q, target_high_q ? pos_low_q : pos_high_q)
					<= deadband_q);
			end
		end
		nxt_target = nxt_target_high ? pos_high_q : pos_low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_high_q <= 1'b1;
			elapsed_q     <= '0;
			settled_q     <= 1'b1;
			last_pos_q    <= '0;
			pwm_down_q    <= '0;
			pwm_up_q      <= '0;
		end else if (fin_fire) begin
			target_high_q <= nxt_target_high;
			elapsed_q     <= nxt_elapsed;
			settled_q     <= nxt_settled;
			last_pos_q    <= nxt_last_pos;
			pwm_down_q    <= nxt_pwm_down;
			pwm_up_q      <= nxt_pwm_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			result_q.pwm_down  <= nxt_pwm_down;
			result_q.pwm_up    <= nxt_pwm_up;
			result_q.position  <= nxt_last_pos;
			result_q.target    <= nxt_target;
			result_q.at_target <= nxt_settled;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_one_line_driven: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pwm_down == '0) || (result.pwm_up == '0))
		else $error("both drive lines active");

	a_stopped_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.at_target) |-> (result.pwm_down == '0) && (result.pwm_up == '0))
		else $error("drive active while at target");

	a_mul_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mul_stat.done) |=> (state_q == ST_DIV) && div_stat.busy)
		else $error("divider not started after multiplier");

	a_one_item_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("second item taken while one is in work");
`endif

endmodule

`default_nettype wire

### rtl/core/mfpc_mul.sv
// Bit-serial shift-add multiplier: 8 x 8 bits, one multiplier bit per cycle.
// Depends on mfpc_pkg.
`default_nettype none

module mfpc_mul
	import mfpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [POS_W-1:0]  mcand,
	input  wire logic [POS_W-1:0]  mplier,
	output logic [PROD_W-1:0]      prod,
	output serial_stat_t           stat
);

	localparam int CNT_W = $clog2(POS_W + 1);

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [POS_W-1:0]  mplier_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(POS_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod      = acc_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

### rtl/core/mfpc_div.sv
// Bit-serial restoring divider by the easing constant (65 or 225), one quotient
// bit per cycle; the quotient is known to fit 8 bits. Depends on mfpc_pkg.
`default_nettype none

module mfpc_div
	import mfpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] num,
	input  wire logic              quad,
	output logic [POS_W-1:0]       quot,
	output serial_stat_t           stat
);

	localparam int CNT_W = $clog2(POS_W + 1);

	logic [POS_W-1:0] rem_q;
	logic [POS_W-1:0] low_q;
	logic [POS_W-1:0] quot_q;
	logic [POS_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [POS_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, low_q[POS_W-1]};
		fits  = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(POS_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= num[PROD_W-1:POS_W];
			low_q     <= num[POS_W-1:0];
			quot_q    <= '0;
			divisor_q <= quad ? QUAD_DIV : LIN_DIV;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? POS_W'(trial - {1'b0, divisor_q}) : trial[POS_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[POS_W-2:0], fits};
		end
	end

	assign quot      = quot_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire
